// ===== rtl/core/rme_pkg.sv =====
package rme_pkg;

	// default configuration
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// extra low bits on the cordic operands
	localparam int GUARD_BITS = 8;

	// angle accumulator, q2.30 with headroom for the start angle
	localparam int ACC_W = 34;

	// singularity limit register width
	localparam int LIM_W = 16;

	// floor(pi * 2^30 + 1/2)
	localparam logic signed [ACC_W-1:0] PI_Q30 = 34'sd3373259426;

	// floor(atan(2^-i) * 2^30)
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h3243F6A8;
			5'd1:    r = 32'h1DAC6705;
			5'd2:    r = 32'h0FADBAFC;
			5'd3:    r = 32'h07F56EA6;
			5'd4:    r = 32'h03FEAB76;
			5'd5:    r = 32'h01FFD55B;
			5'd6:    r = 32'h00FFFAAA;
			5'd7:    r = 32'h007FFF55;
			5'd8:    r = 32'h003FFFEA;
			5'd9:    r = 32'h001FFFFD;
			5'd10:   r = 32'h000FFFFF;
			5'd11:   r = 32'h0007FFFF;
			5'd12:   r = 32'h0003FFFF;
			5'd13:   r = 32'h0001FFFF;
			5'd14:   r = 32'h0000FFFF;
			5'd15:   r = 32'h00007FFF;
			5'd16:   r = 32'h00003FFF;
			5'd17:   r = 32'h00001FFF;
			5'd18:   r = 32'h00000FFF;
			5'd19:   r = 32'h000007FF;
			5'd20:   r = 32'h000003FF;
			5'd21:   r = 32'h000001FF;
			5'd22:   r = 32'h000000FF;
			5'd23:   r = 32'h0000007F;
			5'd24:   r = 32'h0000003F;
			5'd25:   r = 32'h0000001F;
			5'd26:   r = 32'h0000000F;
			5'd27:   r = 32'h00000007;
			5'd28:   r = 32'h00000003;
			5'd29:   r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/rme_isqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
module rme_isqrt #(
	parameter int IN_W = 18,
	parameter int SB_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2*IN_W-1:0]   radicand,
	input  logic [SB_W-1:0]     in_sb,
	output logic                out_valid,
	output logic [IN_W-1:0]     root,
	output logic [SB_W-1:0]     out_sb
);

	localparam int RW    = 2 * IN_W;
	localparam int REM_W = IN_W + 3;

	logic              v_s   [IN_W];
	logic [RW-1:0]     rad_s [IN_W];
	logic [REM_W-1:0]  rem_s [IN_W];
	logic [IN_W-1:0]   rt_s  [IN_W];
	logic [SB_W-1:0]   sb_s  [IN_W];

	for (genvar k = 0; k < IN_W; k++) begin : g_stage
		logic              p_v;
		logic [RW-1:0]     p_rad;
		logic [REM_W-1:0]  p_rem;
		logic [IN_W-1:0]   p_rt;
		logic [SB_W-1:0]   p_sb;
		logic [REM_W-1:0]  rem_n;
		logic [REM_W-1:0]  trial;

		if (k == 0) begin : g_first
			assign p_v   = in_valid;
			assign p_rad = radicand;
			assign p_rem = '0;
			assign p_rt  = '0;
			assign p_sb  = in_sb;
		end else begin : g_next
			assign p_v   = v_s[k-1];
			assign p_rad = rad_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_rt  = rt_s[k-1];
			assign p_sb  = sb_s[k-1];
		end

		// bring down the next bit pair and form the trial divisor
		assign rem_n = {p_rem[REM_W-3:0], p_rad[RW-1:RW-2]};
		assign trial = {1'b0, p_rt, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k] <= p_rad << 2;
			sb_s[k]  <= p_sb;
			if (rem_n >= trial) begin
				rem_s[k] <= rem_n - trial;
				rt_s[k]  <= {p_rt[IN_W-2:0], 1'b1};
			end else begin
				rem_s[k] <= rem_n;
				rt_s[k]  <= {p_rt[IN_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s[IN_W-1];
	assign root      = rt_s[IN_W-1];
	assign out_sb    = sb_s[IN_W-1];

endmodule

// ===== rtl/core/rme_cordic.sv =====
// pipelined vectoring cordic atan2, one micro rotation per stage
module rme_cordic #(
	parameter int IN_W      = 18,
	parameter int FRAC_BITS = 16,
	parameter int STEPS     = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic signed [IN_W:0]       y_in,
	input  logic signed [IN_W:0]       x_in,
	output logic                       out_valid,
	output logic signed [FRAC_BITS+2:0] angle
);

	localparam int OP_W  = IN_W + 1;
	localparam int DW    = OP_W + 1 + rme_pkg::GUARD_BITS + 3;
	localparam int ACC_W = rme_pkg::ACC_W;
	localparam int OUT_W = FRAC_BITS + 3;
	localparam int RSH   = 30 - FRAC_BITS;
	localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'((64'(1) << RSH) >> 1);
	localparam logic signed [ACC_W-1:0] PI = rme_pkg::PI_Q30;

	logic                    v_s    [STEPS+1];
	logic                    zero_s [STEPS+1];
	logic signed [DW-1:0]    x_s    [STEPS+1];
	logic signed [DW-1:0]    y_s    [STEPS+1];
	logic signed [ACC_W-1:0] z_s    [STEPS+1];

	logic signed [DW-1:0] xe, ye;
	assign xe = {{(DW-OP_W){x_in[OP_W-1]}}, x_in};
	assign ye = {{(DW-OP_W){y_in[OP_W-1]}}, y_in};

	// left half plane fold, zero vector detect and guard scaling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in[OP_W-1]) begin
			x_s[0] <= (-xe) <<< rme_pkg::GUARD_BITS;
			y_s[0] <= (-ye) <<< rme_pkg::GUARD_BITS;
			z_s[0] <= y_in[OP_W-1] ? -PI : PI;
		end else begin
			x_s[0] <= xe <<< rme_pkg::GUARD_BITS;
			y_s[0] <= ye <<< rme_pkg::GUARD_BITS;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [DW-1:0]    dx, dy;
		logic signed [ACC_W-1:0] da;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = $signed({2'b00, rme_pkg::atan_q30(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (!y_s[i][DW-1] && (y_s[i] != '0)) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + da;
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - da;
			end
		end
	end

	// clamp to plus or minus pi and round half up
	logic signed [ACC_W-1:0] zc;
	logic signed [ACC_W:0]   zr;
	always_comb begin
		if (z_s[STEPS] > PI) begin
			zc = PI;
		end else if (z_s[STEPS] < -PI) begin
			zc = -PI;
		end else begin
			zc = z_s[STEPS];
		end
		zr = ({zc[ACC_W-1], zc} + HALF) >>> RSH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		angle <= zero_s[STEPS] ? '0 : zr[OUT_W-1:0];
	end

endmodule

// ===== rtl/core/rotation_matrix_to_euler_angles.sv =====
// Rotation matrix to x-y-z Euler angles.
// Request channel: drive r00..r22 (signed q1.FRAC_BITS) and pulse start; a
// request is taken at every rising edge with start high and busy low. busy
// stays low, so one matrix may enter in every cycle.
// Result channel: done is high for one cycle with angle_x, angle_y, angle_z
// (signed q2.FRAC_BITS radians) and is_singular. The receiver cannot stall;
// results come out in request order and must be taken when shown.
// Throughput is one matrix per cycle. The pipeline is the request capture,
// the square, the sum, one square root stage per root bit, an operand select,
// and the cordic pipeline (fold, one stage per step, round) plus the output.
// Configuration: cfg_data sets the singularity limit when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Reset: all pipeline valid bits clear at once, so nothing is in flight, and
// the limit returns to 1.
module rotation_matrix_to_euler_angles #(
	parameter int FRAC_BITS    = rme_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [FRAC_BITS+1:0] r00,
	input  logic signed [FRAC_BITS+1:0] r10,
	input  logic signed [FRAC_BITS+1:0] r11,
	input  logic signed [FRAC_BITS+1:0] r12,
	input  logic signed [FRAC_BITS+1:0] r20,
	input  logic signed [FRAC_BITS+1:0] r21,
	input  logic signed [FRAC_BITS+1:0] r22,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rme_pkg::LIM_W-1:0]   cfg_data,
	output logic                        done,
	output logic signed [FRAC_BITS+2:0] angle_x,
	output logic signed [FRAC_BITS+2:0] angle_y,
	output logic signed [FRAC_BITS+2:0] angle_z,
	output logic                        is_singular
);

	localparam int IN_W  = FRAC_BITS + 2;
	localparam int OUT_W = FRAC_BITS + 3;
	localparam int OP_W  = IN_W + 1;
	localparam int SB_W  = 7 * IN_W;
	localparam int LIM_W = rme_pkg::LIM_W;
	localparam int DL    = CORDIC_STEPS + 2;
	localparam int LAT   = IN_W + CORDIC_STEPS + 7;
	localparam int RSH   = 30 - FRAC_BITS;
	localparam logic signed [rme_pkg::ACC_W:0] PI_OUT =
		({1'b0, rme_pkg::PI_Q30} + (rme_pkg::ACC_W+1)'((64'(1) << RSH) >> 1)) >>> RSH;
	localparam logic signed [OUT_W-1:0] PI_A = PI_OUT[OUT_W-1:0];
	localparam logic signed [OUT_W-1:0] HALF_PI_A =
		(PI_A >>> 1) + OUT_W'(2 ** (FRAC_BITS - 6)) + OUT_W'(2);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// singularity limit register
	logic [LIM_W-1:0] lim_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			lim_q <= cfg_data;
		end
	end

	// stage 1: capture the request
	logic            v_s1;
	logic [SB_W-1:0] m_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end
	always_ff @(posedge clk) begin
		m_s1 <= {r00, r10, r11, r12, r20, r21, r22};
	end

	// stage 2: squares of r00 and r10
	logic                       v_s2;
	logic [SB_W-1:0]            m_s2;
	logic [2*IN_W-1:0]          sq0_s2, sq1_s2;
	logic signed [IN_W-1:0]     a00, a10;
	logic signed [2*IN_W-1:0]   sq00, sq10;
	assign a00  = $signed(m_s1[SB_W-1 -: IN_W]);
	assign a10  = $signed(m_s1[SB_W-IN_W-1 -: IN_W]);
	assign sq00 = a00 * a00;
	assign sq10 = a10 * a10;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		m_s2   <= m_s1;
		sq0_s2 <= $unsigned(sq00);
		sq1_s2 <= $unsigned(sq10);
	end

	// stage 3: sum of squares
	logic              v_s3;
	logic [SB_W-1:0]   m_s3;
	logic [2*IN_W-1:0] sum_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		m_s3   <= m_s2;
		sum_s3 <= sq0_s2 + sq1_s2;
	end

	// sy = floor(sqrt(sum))
	logic            sq_v;
	logic [IN_W-1:0] sy;
	logic [SB_W-1:0] m_q;
	rme_isqrt #(.IN_W(IN_W), .SB_W(SB_W)) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.radicand  (sum_s3),
		.in_sb     (m_s3),
		.out_valid (sq_v),
		.root      (sy),
		.out_sb    (m_q)
	);

	logic signed [IN_W-1:0] q00, q10, q11, q12, q20, q21, q22;
	assign {q00, q10, q11, q12, q20, q21, q22} = m_q;

	// singular decision and cordic operand select
	logic                   sing;
	logic                   v_sel;
	logic                   sing_sel;
	logic signed [OP_W-1:0] xy_sel, xx_sel, yy_sel, yx_sel, zy_sel, zx_sel;
	assign sing = {{LIM_W{1'b0}}, sy} < {{IN_W{1'b0}}, lim_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sel <= 1'b0;
		end else begin
			v_sel <= sq_v;
		end
	end
	always_ff @(posedge clk) begin
		sing_sel <= sing;
		yy_sel   <= -{q20[IN_W-1], q20};
		yx_sel   <= {1'b0, sy};
		zy_sel   <= {q10[IN_W-1], q10};
		zx_sel   <= {q00[IN_W-1], q00};
		if (sing) begin
			xy_sel <= -{q12[IN_W-1], q12};
			xx_sel <= {q11[IN_W-1], q11};
		end else begin
			xy_sel <= {q21[IN_W-1], q21};
			xx_sel <= {q22[IN_W-1], q22};
		end
	end

	// singular flag follows the cordic latency
	logic [DL-1:0] sing_d;
	always_ff @(posedge clk) begin
		sing_d <= {sing_d[DL-2:0], sing_sel};
	end

	logic                    cx_v, cy_v, cz_v;
	logic signed [OUT_W-1:0] ax, ay, az;

	rme_cordic #(.IN_W(IN_W), .FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS)) u_cordic_x (
		.clk (clk), .arst_n (arst_n), .in_valid (v_sel),
		.y_in (xy_sel), .x_in (xx_sel), .out_valid (cx_v), .angle (ax)
	);
	rme_cordic #(.IN_W(IN_W), .FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS)) u_cordic_y (
		.clk (clk), .arst_n (arst_n), .in_valid (v_sel),
		.y_in (yy_sel), .x_in (yx_sel), .out_valid (cy_v), .angle (ay)
	);
	rme_cordic #(.IN_W(IN_W), .FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS)) u_cordic_z (
		.clk (clk), .arst_n (arst_n), .in_valid (v_sel),
		.y_in (zy_sel), .x_in (zx_sel), .out_valid (cz_v), .angle (az)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cx_v && cy_v && cz_v;
		end
	end
	always_ff @(posedge clk) begin
		angle_x     <= ax;
		angle_y     <= ay;
		angle_z     <= sing_d[DL-1] ? '0 : az;
		is_singular <= sing_d[DL-1];
	end

	// every request yields a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after pipeline latency");

	// x and z stay within plus or minus pi
	a_xz_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_x <= PI_A) && (angle_x >= -PI_A) &&
			(angle_z <= PI_A) && (angle_z >= -PI_A))
		else $error("angle x or z beyond pi");

	// sy is never negative, so y stays near the right half plane
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_y <= HALF_PI_A) && (angle_y >= -HALF_PI_A))
		else $error("angle y beyond pi/2");

	// a singular result carries no z rotation
	a_sing_z: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_singular |-> $past(sing_d[DL-1]) && (angle_z == '0))
		else $error("singular result with nonzero z");

endmodule
